>>> rtl/bb3_pkg.sv
// Shared types and constants for the 3x3 box blur stream core.
// No dependencies; imported by every module of the block but bb3_line_store.
package bb3_pkg;

    localparam int VALUE_W    = 16;  // out_value / pixel_value port width
    localparam int POS_W      = 10;  // out_row / out_column width
    localparam int CFG_W      = 11;  // configuration data width
    localparam int MIN_DIM    = 3;   // smallest usable frame width / height

    // Divide by the window size through a reciprocal multiply
    localparam int DIVISOR    = 9;
    localparam int DIV_STAGES = 1;   // product stage after the divider's input register

    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    // Position and selection info that follows an item down the pipeline
    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] column;
        logic             frame_end;
        logic             border;
    } meta_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   column;
        logic               frame_end;
    } res_t;

endpackage

>>> rtl/bb3_line_store.sv
// Two-row line store: one synchronous RAM word holds {upper row, lower row} per column.
// One read and one write port, registered read data. Depends on nothing.
module bb3_line_store #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/bb3_div9.sv
// Pipelined divide by nine through a reciprocal multiply.
// Carries a tag alongside each dividend. Uses bb3_pkg.
module bb3_div9 #(
    parameter int N     = 20,
    parameter int TAG_W = 38
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [N-1:0]     in_dividend,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [N-1:0]     out_quotient,
    output logic [TAG_W-1:0] out_tag
);
    import bb3_pkg::*;

    // ceil(2^(N+3) / 9) fits in N bits; its rounding error stays below one
    // quotient step for every N-bit dividend
    localparam int           SHIFT      = N + 3;
    localparam logic [63:0]  RECIP_FULL = ((64'd1 << SHIFT) + 64'(DIVISOR - 1)) / 64'(DIVISOR);
    localparam logic [N-1:0] RECIP      = RECIP_FULL[N-1:0];

    logic             in_valid_reg;
    logic             prod_valid_reg;
    logic [N-1:0]     num_reg;
    logic [TAG_W-1:0] in_tag_reg;
    logic [TAG_W-1:0] prod_tag_reg;
    logic [2*N-1:0]   prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= in_valid;
            prod_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg      <= in_dividend;
        in_tag_reg   <= in_tag;
        prod_reg     <= (2*N)'(num_reg) * (2*N)'(RECIP);
        prod_tag_reg <= in_tag_reg;
    end

    assign out_valid    = prod_valid_reg;
    assign out_quotient = N'(prod_reg[2*N-1:SHIFT]);
    assign out_tag      = prod_tag_reg;

endmodule

>>> rtl/bb3_out_fifo.sv
// Output result queue: absorbs the pipeline contents while the receiver stalls.
// Register-based circular buffer of res_t items. Uses bb3_pkg.
module bb3_out_fifo #(
    parameter int DEPTH = 9
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bb3_pkg::res_t push_data,
    input  logic          pop,
    output logic          out_valid,
    output bb3_pkg::res_t out_data
);
    import bb3_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    res_t             entry [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // caller keeps the queue from overflowing by credit
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = entry[rd_ptr_reg];

endmodule

>>> rtl/box_blur_3x3_stream_core.sv
// 3x3 box blur over a raster-order frame.
// Input channel (in_valid / in_stall): one item per pixel (action = 0), then
// frame_width+1 flush items (action = 1) after the frame's last pixel. Items of
// the wrong kind for the current phase are taken and dropped.
// Output channel (out_valid / out_stall): output pixels in raster order, one row
// plus one pixel behind the input; border pixels pass through, interior pixels
// are the 3x3 sum divided by nine, truncated. frame_end marks the last one.
// Throughput: one item per clock. An item is accepted every cycle while fewer
// than the output queue depth are held between input and output.
// Path of an accepted item to out_valid: line RAM read, window update, divider
// input, reciprocal product, then the output queue.
// Stalling the output holds results in a small queue; once the pipeline and the
// queue together hold as many items as the queue is deep, in_stall rises. Nothing is lost.
// Reset: width and height return to 17, the frame position to its start; the
// line RAM is not cleared, and at the start of a frame it is read before it is written.
// A configuration write (cfg_we) restarts the frame; write only while idle.
module box_blur_3x3_stream_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         action,
    input  logic [bb3_pkg::VALUE_W-1:0]  pixel_value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bb3_pkg::VALUE_W-1:0]  out_value,
    output logic [bb3_pkg::POS_W-1:0]    out_row,
    output logic [bb3_pkg::POS_W-1:0]    out_column,
    output logic                         frame_end,
    input  logic                         cfg_we,
    input  bb3_pkg::cfg_index_t          cfg_index,
    input  logic [bb3_pkg::CFG_W-1:0]    cfg_data
);
    import bb3_pkg::*;

    localparam int P          = PIXEL_BITS;
    localparam int XW         = $clog2(MAX_WIDTH);
    localparam int WW         = $clog2(MAX_WIDTH + 1);
    localparam int FW         = $clog2(MAX_WIDTH + 2);
    localparam int HW         = $clog2(MAX_HEIGHT + 1);
    localparam int YW         = $clog2(MAX_HEIGHT + 2);
    localparam int COL_W      = P + 2;
    localparam int SUM_W      = P + 4;
    localparam int OUT_DEPTH  = DIV_STAGES + 6;
    localparam int OCC_W      = $clog2(OUT_DEPTH + 1);
    localparam int META_W     = $bits(meta_t);
    localparam int TAG_W      = P + META_W;
    localparam int W_RESET    = (17 < MAX_WIDTH) ? 17 : MAX_WIDTH;
    localparam int H_RESET    = (17 < MAX_HEIGHT) ? 17 : MAX_HEIGHT;

    // frame geometry (stored already clamped) and position
    logic [WW-1:0]    width_reg, width_next;
    logic [HW-1:0]    height_reg, height_next;
    logic [XW-1:0]    col_reg, col_next;
    logic [YW-1:0]    row_reg, row_next;
    logic [FW-1:0]    flush_reg, flush_next;
    logic [OCC_W-1:0] occ_reg, occ_next;

    logic [WW-1:0]    width_clamped;
    logic [HW-1:0]    height_clamped;
    logic             flushing, take, live, x_last, x0, has_res, drop, pop;
    logic [YW-1:0]    row_inc;
    logic [P-1:0]     pix;
    meta_t            meta_in;

    // stage 1: line RAM data returns
    logic             s1_valid_reg, s1_res_reg;
    meta_t            s1_meta_reg;
    logic [P-1:0]     s1_pix_reg;
    logic [XW-1:0]    s1_addr_reg;
    logic [2*P-1:0]   rd_data;
    logic [P-1:0]     upper, lower;
    logic [COL_W-1:0] col_sum_new;

    // sliding window: column sums and the middle row
    logic [COL_W-1:0] csum0_reg, csum1_reg, csum2_reg;
    logic [P-1:0]     mid1_reg, mid2_reg;

    // stage 2: window holds the item's neighborhood
    logic             s2_valid_reg;
    meta_t            s2_meta_reg;
    logic [SUM_W-1:0] win_sum;

    logic             div_valid;
    logic [SUM_W-1:0] div_quo;
    logic [TAG_W-1:0] div_tag;
    meta_t            div_meta;
    logic [P-1:0]     div_mid;
    res_t             push_data, head;

    always_comb
    begin
        if (cfg_data < CFG_W'(MIN_DIM))
        begin
            width_clamped  = WW'(MIN_DIM);
            height_clamped = HW'(MIN_DIM);
        end
        else
        begin
            width_clamped  = (32'(cfg_data) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_data);
            height_clamped = (32'(cfg_data) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_data);
        end
    end

    assign flushing = (flush_reg != '0);
    assign take     = in_valid && !in_stall;
    assign live     = take && (action == flushing);
    assign x_last   = (WW'(col_reg) == width_reg - WW'(1));
    assign x0       = (col_reg == '0);
    assign row_inc  = row_reg + YW'(1);
    assign has_res  = (row_reg >= YW'(2)) || ((row_reg == YW'(1)) && !x0);
    assign pix      = action ? '0 : P'(pixel_value);

    // first column of a row emits the last column of the row two up
    always_comb
    begin
        meta_in.row       = x0 ? POS_W'(row_reg - YW'(2)) : POS_W'(row_reg - YW'(1));
        meta_in.column    = x0 ? POS_W'(width_reg - WW'(1)) : POS_W'(col_reg - XW'(1));
        meta_in.frame_end = action && (flush_reg == FW'(1));
        meta_in.border    = x0 || (col_reg == XW'(1)) || (row_reg == YW'(1)) ||
                            (row_reg >= YW'(height_reg));
    end

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        flush_next  = flush_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  width_next  = width_clamped;
                CFG_FRAME_HEIGHT: height_next = height_clamped;
            endcase
            col_next   = '0;
            row_next   = '0;
            flush_next = '0;
        end
        else if (live)
        begin
            if (action)
            begin
                flush_next = flush_reg - FW'(1);
            end
            if (x_last)
            begin
                col_next = '0;
                row_next = row_inc;
            end
            else
            begin
                col_next = col_reg + XW'(1);
            end
            if (!action && x_last && (row_inc == YW'(height_reg)))
            begin
                flush_next = FW'(width_reg) + FW'(1);
            end
            if (meta_in.frame_end)
            begin
                col_next   = '0;
                row_next   = '0;
                flush_next = '0;
            end
        end
    end

    // items in flight or queued; stall before the queue could overflow
    assign drop     = s1_valid_reg && !s1_res_reg;
    assign pop      = out_valid && !out_stall;
    assign occ_next = occ_reg + OCC_W'(live) - OCC_W'(drop) - OCC_W'(pop);
    assign in_stall = (occ_reg >= OCC_W'(OUT_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WW'(W_RESET);
            height_reg   <= HW'(H_RESET);
            col_reg      <= '0;
            row_reg      <= '0;
            flush_reg    <= '0;
            occ_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            flush_reg    <= flush_next;
            occ_reg      <= occ_next;
            s1_valid_reg <= live;
            s2_valid_reg <= s1_valid_reg && s1_res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_res_reg  <= has_res;
        s1_meta_reg <= meta_in;
        s1_pix_reg  <= pix;
        s1_addr_reg <= col_reg;
        s2_meta_reg <= s1_meta_reg;
    end

    // read column now, write {lower, new pixel} back in the next cycle
    bb3_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (XW),
        .DATA_W (2 * P)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (live),
        .rd_addr (col_reg),
        .rd_data (rd_data),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data ({lower, s1_pix_reg})
    );

    assign upper       = rd_data[2*P-1:P];
    assign lower       = rd_data[P-1:0];
    assign col_sum_new = COL_W'(upper) + COL_W'(lower) + COL_W'(s1_pix_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            csum0_reg <= '0;
            csum1_reg <= '0;
            csum2_reg <= '0;
            mid1_reg  <= '0;
            mid2_reg  <= '0;
        end
        else if (s1_valid_reg)
        begin
            csum0_reg <= csum1_reg;
            csum1_reg <= csum2_reg;
            csum2_reg <= col_sum_new;
            mid1_reg  <= mid2_reg;
            mid2_reg  <= lower;
        end
    end

    assign win_sum = SUM_W'(csum0_reg) + SUM_W'(csum1_reg) + SUM_W'(csum2_reg);

    bb3_div9 #(
        .N     (SUM_W),
        .TAG_W (TAG_W)
    ) u_div9 (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s2_valid_reg),
        .in_dividend  (win_sum),
        .in_tag       ({mid1_reg, s2_meta_reg}),
        .out_valid    (div_valid),
        .out_quotient (div_quo),
        .out_tag      (div_tag)
    );

    assign div_meta = meta_t'(div_tag[META_W-1:0]);
    assign div_mid  = div_tag[TAG_W-1:META_W];

    always_comb
    begin
        push_data.value     = div_meta.border ? VALUE_W'(div_mid) : VALUE_W'(div_quo);
        push_data.row       = div_meta.row;
        push_data.column    = div_meta.column;
        push_data.frame_end = div_meta.frame_end;
    end

    bb3_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (div_valid),
        .push_data (push_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_data  (head)
    );

    assign out_value  = head.value;
    assign out_row    = head.row;
    assign out_column = head.column;
    assign frame_end  = head.frame_end;

endmodule
